// File: sv/vtts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vtts_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TOL_W = 15;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_DEDUP  = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         position;
    logic               binary_mode;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
    logic signed [15:0] comp_w;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] result_index;
    logic [8:0] entry_count;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
    S_FL_RD, S_FL_CMP, S_BN_RD, S_BN_CMP, S_BN_LAST, S_MK_CLR,
    S_DD_RD, S_DD_CHK, S_DDJ_RD, S_DDJ_CMP, S_CP_RD, S_CP_WR, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_RESULT, CMD_CLEAR,
    CMD_INS_RD, CMD_INS_WR, CMD_INS_PUT,
    CMD_DEL_RD, CMD_DEL_WR, CMD_DEL_END,
    CMD_FL_RD, CMD_FL_NEXT, CMD_HIT_I,
    CMD_BN_RD, CMD_BN_STEP, CMD_HIT_MID,
    CMD_MK_CLR, CMD_I_ZERO, CMD_DD_RD, CMD_DD_NEXT, CMD_DD_TAKE,
    CMD_DDJ_RD, CMD_DDJ_CMP, CMD_CP_WR, CMD_CP_END, CMD_OUT
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    status_t   status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       bin;
    logic       full;
    logic       empty;
    logic       ins_bad;
    logic       del_bad;
    logic       i_gt_pos;
    logic       i1_lt_cnt;
    logic       i_lt_cnt;
    logic       j_lt_cnt;
    logic       lo_lt_hi;
    logic       lo_le_hi;
    logic       cmp_eq;
    logic       cmp_gt;
    logic       mark_q;
    logic       out_free;
  } dp_flags_t;

  // Tolerance compare of a against b; first lane out of tolerance decides.
  // Returns {equal, greater}.
  function automatic logic [1:0] tol_cmp(input logic [63:0] a, input logic [63:0] b,
                                         input logic [TOL_W-1:0] tol);
    logic signed [16:0] d;
    logic        [16:0] m;
    logic               hit;
    logic               gt;
    hit = 1'b0;
    gt  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      d = 17'(signed'(a[16*k +: 16])) - 17'(signed'(b[16*k +: 16]));
      m = d[16] ? 17'(-d) : 17'(d);
      if (!hit && (m > {2'b00, tol})) begin
        hit = 1'b1;
        gt  = !d[16];
      end
    end
    return {!hit, gt};
  endfunction

endpackage
`default_nettype wire

// File: sv/vtts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module vtts_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  vtts_pkg::dp_flags_t   flags,
  output vtts_pkg::dp_cmd_t     cmd
);
  import vtts_pkg::*;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (flags.op) inside
          OP_APPEND, OP_INSERT:
            state_nxt = (flags.full || flags.ins_bad) ? S_OUT : S_INS_RD;
          OP_DELETE:
            state_nxt = (flags.empty || flags.del_bad) ? S_OUT : S_DEL_RD;
          OP_FIND:
            state_nxt = flags.empty ? S_OUT : (flags.bin ? S_BN_RD : S_FL_RD);
          OP_DEDUP: state_nxt = S_MK_CLR;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_INS_RD:  state_nxt = flags.i_gt_pos ? S_INS_WR : S_OUT;
      S_INS_WR:  state_nxt = S_INS_RD;
      S_DEL_RD:  state_nxt = flags.i1_lt_cnt ? S_DEL_WR : S_OUT;
      S_DEL_WR:  state_nxt = S_DEL_RD;
      S_FL_RD:   state_nxt = flags.i_lt_cnt ? S_FL_CMP : S_OUT;
      S_FL_CMP:  state_nxt = flags.cmp_eq ? S_OUT : S_FL_RD;
      S_BN_RD: begin
        if (flags.lo_lt_hi)      state_nxt = S_BN_CMP;
        else if (flags.lo_le_hi) state_nxt = S_BN_LAST;
        else                     state_nxt = S_OUT;
      end
      S_BN_CMP:  state_nxt = flags.cmp_eq ? S_OUT : S_BN_RD;
      S_BN_LAST: state_nxt = S_OUT;
      S_MK_CLR:  state_nxt = flags.i_lt_cnt ? S_MK_CLR : S_DD_RD;
      S_DD_RD:   state_nxt = flags.i1_lt_cnt ? S_DD_CHK : S_CP_RD;
      S_DD_CHK:  state_nxt = flags.mark_q ? S_DD_RD : S_DDJ_RD;
      S_DDJ_RD:  state_nxt = flags.j_lt_cnt ? S_DDJ_CMP : S_DD_RD;
      S_DDJ_CMP: state_nxt = S_DDJ_RD;
      S_CP_RD:   state_nxt = flags.i_lt_cnt ? S_CP_WR : S_OUT;
      S_CP_WR:   state_nxt = S_CP_RD;
      S_OUT:     if (flags.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.code   = CMD_NOP;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE:     if (in_valid) cmd.code = CMD_LOAD;
      S_DISPATCH: begin
        case (flags.op) inside
          OP_APPEND, OP_INSERT: begin
            if (flags.full) begin
              cmd.code = CMD_RESULT; cmd.status = ST_FULL;
            end else if (flags.ins_bad) begin
              cmd.code = CMD_RESULT; cmd.status = ST_BAD_INDEX;
            end
          end
          OP_DELETE: begin
            if (flags.empty) begin
              cmd.code = CMD_RESULT; cmd.status = ST_EMPTY;
            end else if (flags.del_bad) begin
              cmd.code = CMD_RESULT; cmd.status = ST_BAD_INDEX;
            end
          end
          OP_FIND: begin
            if (flags.empty) begin
              cmd.code = CMD_RESULT; cmd.status = ST_NOT_FOUND;
            end
          end
          OP_DEDUP: cmd.code = CMD_NOP;
          OP_CLEAR: cmd.code = CMD_CLEAR;
          default:  cmd.code = CMD_RESULT;
        endcase
      end
      S_INS_RD:  cmd.code = flags.i_gt_pos ? CMD_INS_RD : CMD_INS_PUT;
      S_INS_WR:  cmd.code = CMD_INS_WR;
      S_DEL_RD:  cmd.code = flags.i1_lt_cnt ? CMD_DEL_RD : CMD_DEL_END;
      S_DEL_WR:  cmd.code = CMD_DEL_WR;
      S_FL_RD: begin
        if (flags.i_lt_cnt) begin
          cmd.code = CMD_FL_RD;
        end else begin
          cmd.code = CMD_RESULT; cmd.status = ST_NOT_FOUND;
        end
      end
      S_FL_CMP:  cmd.code = flags.cmp_eq ? CMD_HIT_I : CMD_FL_NEXT;
      S_BN_RD: begin
        if (flags.lo_le_hi) begin
          cmd.code = CMD_BN_RD;
        end else begin
          cmd.code = CMD_RESULT; cmd.status = ST_NOT_FOUND;
        end
      end
      S_BN_CMP:  cmd.code = flags.cmp_eq ? CMD_HIT_MID : CMD_BN_STEP;
      S_BN_LAST: begin
        if (flags.cmp_eq) begin
          cmd.code = CMD_HIT_MID;
        end else begin
          cmd.code = CMD_RESULT; cmd.status = ST_NOT_FOUND;
        end
      end
      S_MK_CLR:  cmd.code = flags.i_lt_cnt ? CMD_MK_CLR : CMD_I_ZERO;
      S_DD_RD:   cmd.code = flags.i1_lt_cnt ? CMD_DD_RD : CMD_I_ZERO;
      S_DD_CHK:  cmd.code = flags.mark_q ? CMD_DD_NEXT : CMD_DD_TAKE;
      S_DDJ_RD:  cmd.code = flags.j_lt_cnt ? CMD_DDJ_RD : CMD_DD_NEXT;
      S_DDJ_CMP: cmd.code = CMD_DDJ_CMP;
      S_CP_RD:   cmd.code = flags.i_lt_cnt ? CMD_DD_RD : CMD_CP_END;
      S_CP_WR:   cmd.code = CMD_CP_WR;
      S_OUT:     if (flags.out_free) cmd.code = CMD_OUT;
      default:   cmd.code = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/vtts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module vtts_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  vtts_pkg::in_item_t            in_data,
  input  wire                           cfg_we,
  input  wire [vtts_pkg::TOL_W-1:0]     cfg_data,
  input  vtts_pkg::dp_cmd_t             cmd,
  output vtts_pkg::dp_flags_t           flags,
  input  wire                           out_stall,
  output logic                          out_valid,
  output vtts_pkg::out_item_t           out_data
);
  import vtts_pkg::*;

  logic [63:0]             store_mem [DEPTH];
  logic                    mark_mem  [DEPTH];

  logic [CNT_W-1:0]        count_r;
  logic [TOL_W-1:0]        tol_r;
  logic [2:0]              op_r;
  logic [CNT_W-1:0]        pos_r;
  logic                    bin_r;
  logic [63:0]             probe_r;
  logic [63:0]             ref_r;
  logic [CNT_W-1:0]        i_r;
  logic [CNT_W-1:0]        j_r;
  logic signed [CNT_W:0]   lo_r;
  logic signed [CNT_W:0]   hi_r;
  logic [IDX_W-1:0]        mid_r;
  status_t                 res_status_r;
  logic [7:0]              res_idx_r;
  logic                    out_valid_r;
  out_item_t               out_r;
  logic [63:0]             rd_q;
  logic                    mark_q;

  logic [IDX_W-1:0]        rd_addr;
  logic                    store_we;
  logic [IDX_W-1:0]        store_waddr;
  logic [63:0]             store_wdata;
  logic                    mark_we;
  logic [IDX_W-1:0]        mark_waddr;
  logic                    mark_wdata;
  logic [CNT_W-1:0]        i_dec;
  logic [CNT_W-1:0]        i_inc;
  logic [CNT_W-1:0]        j_inc;
  logic signed [CNT_W+1:0] mid_sum;
  logic [IDX_W-1:0]        mid_w;
  logic [1:0]              cmp;
  logic [63:0]             cmp_a;
  logic [63:0]             cmp_b;
  logic                    is_dedup;
  logic [63:0]             in_vec;

  assign in_vec   = {in_data.comp_w, in_data.comp_z, in_data.comp_y, in_data.comp_x};
  assign i_dec    = i_r - CNT_W'(1);
  assign i_inc    = i_r + CNT_W'(1);
  assign j_inc    = j_r + CNT_W'(1);
  assign mid_sum  = (CNT_W+2)'(lo_r) + (CNT_W+2)'(hi_r);
  assign mid_w    = mid_sum[IDX_W:1];
  assign is_dedup = (op_r == OP_DEDUP);
  assign cmp_a    = is_dedup ? ref_r : rd_q;
  assign cmp_b    = is_dedup ? rd_q : probe_r;
  assign cmp      = tol_cmp(cmp_a, cmp_b, tol_r);

  always_comb begin
    flags.op        = op_r;
    flags.bin       = bin_r;
    flags.full      = (count_r >= CNT_W'(DEPTH));
    flags.empty     = (count_r == '0);
    flags.ins_bad   = (pos_r > count_r);
    flags.del_bad   = (pos_r >= count_r);
    flags.i_gt_pos  = (i_r > pos_r);
    flags.i1_lt_cnt = (i_inc < count_r);
    flags.i_lt_cnt  = (i_r < count_r);
    flags.j_lt_cnt  = (j_r < count_r);
    flags.lo_lt_hi  = (lo_r < hi_r);
    flags.lo_le_hi  = (lo_r <= hi_r);
    flags.cmp_eq    = cmp[1];
    flags.cmp_gt    = cmp[0];
    flags.mark_q    = mark_q;
    flags.out_free  = !out_valid_r || !out_stall;
  end

  // memory port steering
  always_comb begin
    rd_addr     = i_r[IDX_W-1:0];
    store_we    = 1'b0;
    store_waddr = i_r[IDX_W-1:0];
    store_wdata = rd_q;
    mark_we     = 1'b0;
    mark_waddr  = i_r[IDX_W-1:0];
    mark_wdata  = 1'b0;
    case (cmd.code)
      CMD_INS_RD:  rd_addr = i_dec[IDX_W-1:0];
      CMD_INS_WR:  store_we = 1'b1;
      CMD_INS_PUT: begin
        store_we    = 1'b1;
        store_waddr = pos_r[IDX_W-1:0];
        store_wdata = probe_r;
      end
      CMD_DEL_RD:  rd_addr = i_inc[IDX_W-1:0];
      CMD_DEL_WR:  store_we = 1'b1;
      CMD_BN_RD:   rd_addr = mid_w;
      CMD_MK_CLR:  mark_we = 1'b1;
      CMD_DDJ_RD:  rd_addr = j_r[IDX_W-1:0];
      CMD_DDJ_CMP: begin
        mark_we    = !mark_q && cmp[1];
        mark_waddr = j_r[IDX_W-1:0];
        mark_wdata = 1'b1;
      end
      CMD_CP_WR: begin
        store_we    = !mark_q;
        store_waddr = j_r[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    rd_q   <= store_mem[rd_addr];
    mark_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_data;
      end
      case (cmd.code)
        CMD_INS_PUT: count_r <= count_r + CNT_W'(1);
        CMD_DEL_END: count_r <= count_r - CNT_W'(1);
        CMD_CP_END:  count_r <= j_r;
        CMD_CLEAR:   count_r <= '0;
        default: ;
      endcase
      if (cmd.code == CMD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and result holding
  always_ff @(posedge clk) begin
    case (cmd.code)
      CMD_LOAD: begin
        op_r    <= in_data.opcode;
        bin_r   <= in_data.binary_mode;
        probe_r <= in_vec;
        pos_r   <= (in_data.opcode == OP_APPEND) ? count_r
                                                 : CNT_W'(in_data.position);
        if (in_data.opcode == OP_APPEND || in_data.opcode == OP_INSERT) begin
          i_r <= count_r;
        end else if (in_data.opcode == OP_DELETE) begin
          i_r <= CNT_W'(in_data.position);
        end else begin
          i_r <= '0;
        end
        j_r  <= '0;
        lo_r <= '0;
        hi_r <= (CNT_W+1)'(count_r) - (CNT_W+1)'(1);
      end
      CMD_RESULT: begin
        res_status_r <= cmd.status;
        res_idx_r    <= '0;
      end
      CMD_CLEAR, CMD_CP_END: begin
        res_status_r <= ST_OK;
        res_idx_r    <= '0;
      end
      CMD_INS_WR:  i_r <= i_dec;
      CMD_INS_PUT, CMD_DEL_END: begin
        res_status_r <= ST_OK;
        res_idx_r    <= pos_r[7:0];
      end
      CMD_DEL_WR, CMD_FL_NEXT, CMD_MK_CLR, CMD_DD_NEXT: i_r <= i_inc;
      CMD_HIT_I: begin
        res_status_r <= ST_OK;
        res_idx_r    <= i_r[7:0];
      end
      CMD_BN_RD:   mid_r <= mid_w;
      CMD_BN_STEP: begin
        if (cmp[0]) begin
          hi_r <= (CNT_W+1)'(mid_r) - (CNT_W+1)'(1);
        end else begin
          lo_r <= (CNT_W+1)'(mid_r) + (CNT_W+1)'(1);
        end
      end
      CMD_HIT_MID: begin
        res_status_r <= ST_OK;
        res_idx_r    <= 8'(mid_r);
      end
      CMD_I_ZERO: begin
        i_r <= '0;
        j_r <= '0;
      end
      CMD_DD_TAKE: begin
        ref_r <= rd_q;
        j_r   <= i_inc;
      end
      CMD_DDJ_CMP: j_r <= j_inc;
      CMD_CP_WR: begin
        if (!mark_q) begin
          j_r <= j_inc;
        end
        i_r <= i_inc;
      end
      CMD_OUT: begin
        out_r.status       <= res_status_r;
        out_r.result_index <= res_idx_r;
        out_r.entry_count  <= 9'(count_r);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: sv/vec4_table_tolerance_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                           | Direction
// ---------+---------------------------------+-----------
// input    | in_valid, in_stall, in_data     | items in
// result   | out_valid, out_stall, out_data  | items out
// config   | cfg_we, cfg_data                | tolerance
//
// One item at a time; all table work goes through the single read port of
// the vector store (registered read). Insert and delete shift the entries
// behind the position; linear find scans from entry 0, binary find halves
// the search range. Remove duplicates clears the marks, compares entry pairs
// and marks later duplicates, then compacts the unmarked entries.
// The next item can be accepted in the cycle after the result is registered.
// Reset is synchronous; the table reads empty after it. A held result stalls
// only the finish of the next item, not its acceptance.
module vec4_table_tolerance_search_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  vtts_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output vtts_pkg::out_item_t           out_data,
  input  wire                           cfg_we,
  input  wire [vtts_pkg::TOL_W-1:0]     cfg_data
);
  import vtts_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // sequence the operation
  vtts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  // hold the table, counters, compare unit and result register
  vtts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .flags     (flags),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: sv/vtts_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module vtts_chk (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire                        out_valid,
  input wire                        out_stall,
  input vtts_pkg::out_item_t        out_data
);
  import vtts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_index == 8'd0)
    else $error("index not zero on failure");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 9'(DEPTH))
    else $error("entry count beyond depth");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == 9'(DEPTH))
    else $error("full reported below depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off while an item is in work");

endmodule

bind vec4_table_tolerance_search_core vtts_chk u_chk (.*);
`default_nettype wire
